/* src/lrc_pkg.sv */
package lrc_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int REFS_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  typedef logic [COUNT_W-1:0] count_out_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [DATA_W-1:0]   found_handle;
    logic [REFS_W-1:0]   found_refs;
    logic                evicted;
    logic [DATA_W-1:0]   evicted_handle;
    logic [DATA_W-1:0]   hit_total;
    logic [DATA_W-1:0]   miss_total;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] handle;
    logic [REFS_W-1:0] refs;
  } entry_t;

  typedef struct packed {
    logic cmp;
    logic by_key;
    logic shift;
    logic dec;
  } cell_ctrl_t;

endpackage

/* src/lrc_cell.sv */
module lrc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  lrc_pkg::cell_ctrl_t       ctrl,
  input  logic [lrc_pkg::DATA_W-1:0] cmp_value,
  input  lrc_pkg::entry_t           left,
  output lrc_pkg::entry_t           ent,
  output logic                      match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      match     <= 1'b0;
    end else begin
      // take the neighbor's entry, or count down in place
      if (ctrl.shift) begin
        ent <= left;
      end else if (ctrl.dec && ent.refs != '0) begin
        ent.refs <= ent.refs - 1'b1;
      end
      if (ctrl.cmp) begin
        match <= ent.valid &&
                 (ctrl.by_key ? (ent.key == cmp_value) : (ent.handle == cmp_value));
      end
    end
  end

endmodule

/* src/lrc_select.sv */
module lrc_select #(
  parameter int CAPACITY = lrc_pkg::CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic [CAPACITY-1:0]   match,
  input  lrc_pkg::entry_t       entries [CAPACITY],
  output logic                  any,
  output logic [CAPACITY-1:0]   above,
  output logic [CAPACITY-1:0]   first,
  output lrc_pkg::entry_t       sel
);

  localparam logic [CAPACITY-1:0] ONES = '1;

  logic [CAPACITY-1:0] above_c;
  logic [CAPACITY-1:0] first_c;
  logic [CAPACITY-1:0] key_m    [lrc_pkg::DATA_W];
  logic [CAPACITY-1:0] handle_m [lrc_pkg::DATA_W];
  logic [CAPACITY-1:0] refs_m   [lrc_pkg::REFS_W];
  lrc_pkg::entry_t     sel_c;

  // above[i]: some more recent cell matched
  for (genvar i = 0; i < CAPACITY; i++) begin : g_first
    assign above_c[i] = |(match & (ONES >> (CAPACITY - i)));
    assign first_c[i] = match[i] & ~above_c[i];
  end

  // and-or pick of the single first match, one bit column at a time
  for (genvar b = 0; b < lrc_pkg::DATA_W; b++) begin : g_word
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign key_m[b][i]    = entries[i].key[b];
      assign handle_m[b][i] = entries[i].handle[b];
    end
    assign sel_c.key[b]    = |(first_c & key_m[b]);
    assign sel_c.handle[b] = |(first_c & handle_m[b]);
  end

  for (genvar b = 0; b < lrc_pkg::REFS_W; b++) begin : g_refs
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign refs_m[b][i] = entries[i].refs[b];
    end
    assign sel_c.refs[b] = |(first_c & refs_m[b]);
  end

  assign sel_c.valid = |match;

  always_ff @(posedge clk) begin
    if (load) begin
      any   <= |match;
      above <= above_c;
      first <= first_c;
      sel   <= sel_c;
    end
  end

endmodule

/* src/lru_refcount_cache_top.sv */
// Fully associative LRU cache with reference counts, kept as a chain of
// cells in recency order: cell 0 holds the most recent entry and the valid
// entries always fill cells 0 .. entry_count-1.
// Request channel req (req_valid / req_ready) carries one word: operation,
// key and handle. Response channel rsp (rsp_valid / rsp_ready) returns one
// word for every request.
// A request passes its steps in order: the cells compare in the accept cycle,
// the select stage registers the first match in recency order, and in the
// update state the chain shifts or counts down and the response is registered.
// req_ready is high only in the idle state, so a new request is not taken
// before the last one has reached the update state and left it.
// A finished response sits in the output register; while it waits the next
// request is taken and worked up to the update cycle, where it holds until
// the output register frees.
// Reset (rst, synchronous): all cells invalid, entry count and the hit and
// miss totals zero, no response pending. No clearing pass is needed.
module lru_refcount_cache_top #(
  parameter int CAPACITY = lrc_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lrc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lrc_pkg::rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SEL  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [lrc_pkg::OP_W-1:0]      op_q;
  logic [lrc_pkg::DATA_W-1:0]    key_q;
  logic [lrc_pkg::DATA_W-1:0]    handle_q;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic [lrc_pkg::DATA_W-1:0]    hit_total;
  logic [lrc_pkg::DATA_W-1:0]    hit_total_next;
  logic [lrc_pkg::DATA_W-1:0]    miss_total;
  logic [lrc_pkg::DATA_W-1:0]    miss_total_next;
  lrc_pkg::rsp_t                 rsp_next;

  logic                          accept;
  logic                          upd_go;
  logic                          by_key;
  logic [lrc_pkg::DATA_W-1:0]    cmp_value;
  logic                          do_shift;
  logic                          lookup_hit;
  logic                          do_dec;
  logic                          full;
  logic [lrc_pkg::REFS_W-1:0]    refs_up;
  logic [lrc_pkg::REFS_W-1:0]    refs_down;

  lrc_pkg::cell_ctrl_t           cell_ctrl [CAPACITY];
  lrc_pkg::entry_t               ent       [CAPACITY];
  lrc_pkg::entry_t               left      [CAPACITY];
  lrc_pkg::entry_t               head;
  logic [CAPACITY-1:0]           match;
  logic [CAPACITY-1:0]           valid_vec;

  logic                          sel_any;
  logic [CAPACITY-1:0]           sel_above;
  logic [CAPACITY-1:0]           sel_first;
  lrc_pkg::entry_t               sel;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign upd_go    = (state == S_UPD) && (!rsp_valid || rsp_ready);
  assign by_key    = (req.operation == lrc_pkg::OP_LOOKUP);
  assign cmp_value = by_key ? req.key : req.handle;
  assign full      = (count == CNT_W'(CAPACITY));
  assign refs_up   = (sel.refs == lrc_pkg::REFS_MAX) ? sel.refs : sel.refs + 1'b1;
  assign refs_down = (sel.refs == '0) ? sel.refs : sel.refs - 1'b1;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cells
    if (i == 0) begin : g_head
      assign left[i] = head;
    end else begin : g_link
      assign left[i] = ent[i-1];
    end
    assign valid_vec[i]        = ent[i].valid;
    assign cell_ctrl[i].cmp    = accept;
    assign cell_ctrl[i].by_key = by_key;
    // a lookup hit moves cells down to and including the hit cell
    assign cell_ctrl[i].shift  = upd_go && (do_shift || (lookup_hit && !sel_above[i]));
    assign cell_ctrl[i].dec    = upd_go && do_dec && sel_first[i];

    lrc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl[i]),
      .cmp_value (cmp_value),
      .left      (left[i]),
      .ent       (ent[i]),
      .match     (match[i])
    );
  end

  lrc_select #(
    .CAPACITY (CAPACITY)
  ) u_select (
    .clk     (clk),
    .load    (state == S_SEL),
    .match   (match),
    .entries (ent),
    .any     (sel_any),
    .above   (sel_above),
    .first   (sel_first),
    .sel     (sel)
  );

  always_comb begin
    do_shift        = 1'b0;
    lookup_hit      = 1'b0;
    do_dec          = 1'b0;
    head            = sel;
    count_next      = count;
    hit_total_next  = hit_total;
    miss_total_next = miss_total;
    rsp_next        = '0;

    unique case (op_q)
      lrc_pkg::OP_LOOKUP: begin
        if (sel_any) begin
          lookup_hit            = 1'b1;
          head.valid            = 1'b1;
          head.refs             = refs_up;
          hit_total_next        = hit_total + 1'b1;
          rsp_next.hit          = 1'b1;
          rsp_next.found_handle = sel.handle;
          rsp_next.found_refs   = refs_up;
        end else begin
          miss_total_next = miss_total + 1'b1;
          rsp_next.status = lrc_pkg::ST_MISS;
        end
      end
      lrc_pkg::OP_INSERT: begin
        if (handle_q == '0) begin
          rsp_next.status = lrc_pkg::ST_INVALID;
        end else begin
          do_shift                = 1'b1;
          head.valid              = 1'b1;
          head.key                = key_q;
          head.handle             = handle_q;
          head.refs               = lrc_pkg::REFS_W'(1);
          rsp_next.found_refs     = lrc_pkg::REFS_W'(1);
          // the last cell drops off the chain when full
          rsp_next.evicted        = full;
          rsp_next.evicted_handle = full ? ent[CAPACITY-1].handle : '0;
          count_next              = full ? count : count + 1'b1;
        end
      end
      lrc_pkg::OP_RELEASE: begin
        if (handle_q == '0) begin
          rsp_next.status = lrc_pkg::ST_INVALID;
        end else if (sel_any) begin
          do_dec              = 1'b1;
          rsp_next.found_refs = refs_down;
        end else begin
          rsp_next.status = lrc_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        rsp_next.status = lrc_pkg::ST_INVALID;
      end
    endcase

    rsp_next.hit_total   = hit_total_next;
    rsp_next.miss_total  = miss_total_next;
    rsp_next.entry_count = lrc_pkg::count_out_t'(count_next);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_SEL;
      S_SEL:   state_next = S_UPD;
      S_UPD:   if (upd_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      hit_total  <= '0;
      miss_total <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        count      <= count_next;
        hit_total  <= hit_total_next;
        miss_total <= miss_total_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= req.operation;
      key_q    <= req.key;
      handle_q <= req.handle;
    end
    if (upd_go) begin
      rsp <= rsp_next;
    end
  end

  // an accepted word walks through select and update in order
  a_sequence: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SEL) ##1 (state == S_UPD))
    else $error("request did not pass select and update");

  // entry count tracks the valid cells
  a_count: assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(valid_vec)))
    else $error("entry count differs from valid cells");

  // valid cells stay packed at the head of the chain
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid cells not contiguous from cell 0");

  // the hit total only moves on a lookup update
  a_hits: assert property (@(posedge clk) disable iff (rst)
    !$stable(hit_total) |-> $past(upd_go && op_q == lrc_pkg::OP_LOOKUP))
    else $error("hit total changed outside a lookup");

endmodule

/* tb/tb_lru_refcount_cache_top.sv */
`timescale 1ns / 1ps

module tb_lru_refcount_cache_top;

  localparam int CAPACITY = lrc_pkg::CAPACITY_DEF;
  localparam int KEY_POOL = 24;
  localparam int QUIET_LIMIT = 20000;
  localparam logic [lrc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  lrc_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  lrc_pkg::rsp_t rsp;

  lru_refcount_cache_top #(.CAPACITY(CAPACITY)) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow copy of the cache contents, rank 0 = most recent
  logic [lrc_pkg::DATA_W-1:0] ent_key    [CAPACITY];
  logic [lrc_pkg::DATA_W-1:0] ent_handle [CAPACITY];
  logic [lrc_pkg::REFS_W-1:0] ent_refs   [CAPACITY];
  bit                         ent_valid  [CAPACITY];
  int unsigned                ent_rank   [CAPACITY];
  int unsigned                live_count;
  logic [lrc_pkg::DATA_W-1:0] hit_count;
  logic [lrc_pkg::DATA_W-1:0] miss_count;

  lrc_pkg::rsp_t owed_replies[$];
  logic [lrc_pkg::DATA_W-1:0] key_pool    [KEY_POOL];
  logic [lrc_pkg::DATA_W-1:0] handle_pool [KEY_POOL];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int stall_left = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  function automatic int find_entry(bit by_key, logic [lrc_pkg::DATA_W-1:0] value);
    int best;
    best = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ent_valid[i] && ((by_key ? ent_key[i] : ent_handle[i]) == value)) begin
        if (best < 0 || ent_rank[i] < ent_rank[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic lrc_pkg::rsp_t apply_cache_op(lrc_pkg::req_t w);
    lrc_pkg::rsp_t r;
    int e;
    int slot;
    int unsigned old_rank;
    r = '0;
    r.status = lrc_pkg::ST_OK;
    case (w.operation)
      lrc_pkg::OP_LOOKUP: begin
        e = find_entry(1'b1, w.key);
        if (e >= 0) begin
          old_rank = ent_rank[e];
          hit_count++;
          if (ent_refs[e] != lrc_pkg::REFS_MAX) ent_refs[e]++;
          for (int i = 0; i < CAPACITY; i++)
            if (ent_valid[i] && ent_rank[i] < old_rank) ent_rank[i]++;
          ent_rank[e] = 0;
          r.hit = 1'b1;
          r.found_handle = ent_handle[e];
          r.found_refs = ent_refs[e];
        end else begin
          miss_count++;
          r.status = lrc_pkg::ST_MISS;
        end
      end
      lrc_pkg::OP_INSERT: begin
        if (w.handle == '0) begin
          r.status = lrc_pkg::ST_INVALID;
        end else begin
          slot = -1;
          if (live_count >= CAPACITY) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (ent_valid[i] && ent_rank[i] == live_count - 1 && !r.evicted) begin
                r.evicted = 1'b1;
                r.evicted_handle = ent_handle[i];
                ent_valid[i] = 1'b0;
                live_count--;
              end
            end
          end
          for (int i = 0; i < CAPACITY; i++) begin
            if (ent_valid[i]) ent_rank[i]++;
            else if (slot < 0) slot = i;
          end
          if (slot >= 0) begin
            ent_key[slot] = w.key;
            ent_handle[slot] = w.handle;
            ent_refs[slot] = lrc_pkg::REFS_W'(1);
            ent_valid[slot] = 1'b1;
            ent_rank[slot] = 0;
            live_count++;
            r.found_refs = lrc_pkg::REFS_W'(1);
          end
        end
      end
      lrc_pkg::OP_RELEASE: begin
        if (w.handle == '0) begin
          r.status = lrc_pkg::ST_INVALID;
        end else begin
          e = find_entry(1'b0, w.handle);
          if (e >= 0) begin
            if (ent_refs[e] != '0) ent_refs[e]--;
            r.found_refs = ent_refs[e];
          end else begin
            r.status = lrc_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: r.status = lrc_pkg::ST_INVALID;
    endcase
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    r.entry_count = live_count[lrc_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_word(input lrc_pkg::req_t w);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    owed_replies.push_back(apply_cache_op(w));
  endtask

  task automatic send_op(logic [lrc_pkg::OP_W-1:0] op, logic [lrc_pkg::DATA_W-1:0] key,
                         logic [lrc_pkg::DATA_W-1:0] handle);
    lrc_pkg::req_t w;
    w.operation = op;
    w.key = key;
    w.handle = handle;
    send_word(w);
  endtask

  function automatic lrc_pkg::req_t random_word();
    lrc_pkg::req_t w;
    int pick;
    int slot;
    w.operation = lrc_pkg::OP_LOOKUP;
    w.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    w.handle = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 9) == 0) w.key = $urandom;
    end else if (pick < 75) begin
      w.operation = lrc_pkg::OP_INSERT;
      w.handle = handle_pool[$urandom_range(0, KEY_POOL - 1)];
      if ($urandom_range(0, 19) == 0) w.handle = '0;
      else if ($urandom_range(0, 9) == 0) w.key = $urandom;
    end else if (pick < 95) begin
      w.operation = lrc_pkg::OP_RELEASE;
      slot = $urandom_range(0, CAPACITY - 1);
      // mostly release something that is actually held
      if (ent_valid[slot] && $urandom_range(0, 3) != 0) w.handle = ent_handle[slot];
      else if ($urandom_range(0, 9) == 0) w.handle = '0;
      else if ($urandom_range(0, 4) != 0) w.handle = handle_pool[$urandom_range(0, KEY_POOL - 1)];
    end else begin
      w.operation = OP_UNUSED;
    end
    return w;
  endfunction

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  task automatic test_bad_words();
    send_op(lrc_pkg::OP_LOOKUP, '0, '0);
    send_op(lrc_pkg::OP_INSERT, '1, '0);
    send_op(lrc_pkg::OP_RELEASE, '1, '0);
    send_op(OP_UNUSED, '1, '1);
    send_op(lrc_pkg::OP_RELEASE, '0, '1);
  endtask

  // fill every slot, with a duplicate key, then force one eviction
  task automatic test_fill_and_evict();
    logic [lrc_pkg::DATA_W-1:0] k;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (i == 0) k = '1;
      else if (i == 1 || i == CAPACITY - 1) k = '0;
      else k = 32'h5A00_0000 | i;
      send_op(lrc_pkg::OP_INSERT, k, (i == 0) ? '1 : lrc_pkg::DATA_W'(i));
    end
  endtask

  task automatic test_recency_and_release();
    send_op(lrc_pkg::OP_LOOKUP, 32'h5A00_0002, '0);
    send_op(lrc_pkg::OP_INSERT, 32'h0BAD_F00D, 32'h0000_8000);
    send_op(lrc_pkg::OP_LOOKUP, '0, '0);
    send_op(lrc_pkg::OP_RELEASE, '0, 32'd5);
    send_op(lrc_pkg::OP_RELEASE, '0, 32'd5);
    send_op(lrc_pkg::OP_RELEASE, '0, 32'hDEAD_BEEF);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  // response side stops for a long stretch while requests keep coming
  task automatic test_backpressure();
    stall_request = 250;
    for (int i = 0; i < 24; i++) send_word(random_word());
  endtask

  // count climbs on repeated hits of one entry, then one release
  task automatic test_refs_repeat();
    send_op(lrc_pkg::OP_INSERT, 32'hFEED_0001, 32'h7FFF_FFFF);
    for (int i = 0; i < 60; i++) send_op(lrc_pkg::OP_LOOKUP, 32'hFEED_0001, '0);
    send_op(lrc_pkg::OP_RELEASE, '0, 32'h7FFF_FFFF);
  endtask

  task automatic check_field(string name, logic [lrc_pkg::DATA_W-1:0] exp_v,
                             logic [lrc_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    lrc_pkg::rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (owed_replies.size() == 0) begin
        $error("response word with nothing outstanding");
        error_count++;
      end else begin
        want = owed_replies.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("hit", want.hit, rsp.hit);
        check_field("found_handle", want.found_handle, rsp.found_handle);
        check_field("found_refs", want.found_refs, rsp.found_refs);
        check_field("evicted", want.evicted, rsp.evicted);
        check_field("evicted_handle", want.evicted_handle, rsp.evicted_handle);
        check_field("hit_total", want.hit_total, rsp.hit_total);
        check_field("miss_total", want.miss_total, rsp.miss_total);
        check_field("entry_count", want.entry_count, rsp.entry_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      ent_valid[i] = 1'b0;
      ent_rank[i] = 0;
    end
    live_count = 0;
    hit_count = '0;
    miss_count = '0;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = $urandom;
      handle_pool[i] = $urandom;
      if (handle_pool[i] == '0) handle_pool[i] = 32'd1;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(10, 86);
    test_bad_words();
    test_fill_and_evict();
    test_recency_and_release();
    test_random(300);

    set_idling(86, 10);
    test_backpressure();
    test_random(300);

    set_idling(0, 0);
    test_refs_repeat();
    test_random(300);

    req_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
